@@ sv/scsd_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and decode tables for the serial command display
package scsd_pkg;

    localparam int NumDigits = 8;
    localparam int IdxW      = $clog2(NumDigits);
    localparam int DriveW    = 8;

    localparam logic [7:0] CharA  = 8'h41;
    localparam logic [7:0] CharT  = 8'h54;
    localparam logic [7:0] CharC  = 8'h43;
    localparam logic [7:0] CharN  = 8'h4E;
    localparam logic [7:0] CharCr = 8'h0D;
    localparam logic [7:0] CharLf = 8'h0A;
    localparam logic [7:0] CharO  = 8'h4F;
    localparam logic [7:0] CharK  = 8'h4B;

    localparam logic [3:0] BlankNibble = 4'hA;

    // command flag bits and the accepted combinations
    localparam logic [3:0] FlagA   = 4'b0001;
    localparam logic [3:0] FlagT   = 4'b0010;
    localparam logic [3:0] FlagC   = 4'b0100;
    localparam logic [3:0] FlagN   = 4'b1000;
    localparam logic [3:0] FlagsAt = 4'b0011;

    localparam logic KindRx   = 1'b0;
    localparam logic KindScan = 1'b1;

    localparam logic [1:0] ReplyFirst = 2'd0;
    localparam logic [1:0] ReplyLast  = 2'd3;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic       out_kind;
        logic [7:0] tx_byte;
        logic [7:0] segments;
        logic [7:0] digit_enable;
        logic       last;
    } result_t;

    typedef enum logic [1:0] {
        RES_NONE,
        RES_SCAN,
        RES_REPLY
    } res_kind_t;

    // what the core asks the output stage to send for one item
    typedef struct packed {
        res_kind_t         kind;
        logic [7:0]        segments;
        logic [DriveW-1:0] digit_enable;
    } desc_t;

    // active-low segment pattern, blank above nine except the all-on code
    function automatic logic [7:0] seg_code(input logic [3:0] nib);
        logic [7:0] code;
        case (nib)
            4'd0:    code = 8'hC0;
            4'd1:    code = 8'hF9;
            4'd2:    code = 8'hA4;
            4'd3:    code = 8'hB0;
            4'd4:    code = 8'h99;
            4'd5:    code = 8'h92;
            4'd6:    code = 8'h82;
            4'd7:    code = 8'hF8;
            4'd8:    code = 8'h80;
            4'd9:    code = 8'h90;
            4'd11:   code = 8'h00;
            default: code = 8'hFF;
        endcase
        return code;
    endfunction

    function automatic logic [7:0] reply_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = CharO;
            2'd1:    b = CharK;
            2'd2:    b = CharCr;
            default: b = CharLf;
        endcase
        return b;
    endfunction

endpackage

@@ sv/serial_command_seven_segment_display.sv @@
`timescale 1ns / 1ps
// top level of the serial command seven-segment display
//
// input channel item/item_valid/item_ready: each beat is either a received
// serial byte (kind 0) or a display scan tick (kind 1)
// output channel result/result_valid/result_ready: a scan tick gives one
// display beat (segments and one-hot digit enable, last set); a line feed
// that closes an AT, C or N command gives four reply beats O K CR LF,
// last set on the LF; every other byte only updates internal state
//
// an accepted beat is registered in the input register and its first result is
// then registered in the result register once that register can take it
// throughput: one item per cycle while the receiver keeps up and no reply is
// in flight; a reply holds the result register until its four beats are taken
//
// reset: digits blank, flags and digit counter cleared, scan ring at the top
// digit so the first tick enables digit 0
// when the receiver stalls the result register holds and the input register
// absorbs one more beat before item_ready drops
module serial_command_seven_segment_display (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  scsd_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output scsd_pkg::result_t result
);

    // input register
    logic            in_valid_reg, in_valid_next;
    scsd_pkg::item_t in_item_reg;

    scsd_pkg::desc_t desc;
    logic            can_load;
    logic            no_result;
    logic            consume;
    logic            load;

    // items without a result never wait on the output side
    assign no_result  = (desc.kind == scsd_pkg::RES_NONE);
    assign consume    = in_valid_reg && (no_result || can_load);
    assign load       = consume && !no_result;
    assign item_ready = !in_valid_reg || consume;

    always_comb
    begin
        if (item_valid && item_ready)
            in_valid_next = 1'b1;
        else if (consume)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            in_item_reg <= item;
    end

    scsd_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (in_item_reg),
        .take  (consume),
        .desc  (desc)
    );

    scsd_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (load),
        .desc         (desc),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .result       (result),
        .can_load     (can_load)
    );

    // a reply always ends on the line feed
    a_reply_ends_lf: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.out_kind == scsd_pkg::KindRx && result.last
        |-> result.tx_byte == scsd_pkg::CharLf)
        else $error("reply ended on a byte other than line feed");

    // display beats drive exactly one digit and close their item
    a_scan_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.out_kind == scsd_pkg::KindScan
        |-> $onehot(result.digit_enable) && result.last)
        else $error("display beat without a single enabled digit");

    // a reply beat taken before the end is followed by another reply beat
    a_reply_continues: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && !result.last
        |=> result_valid && result.out_kind == scsd_pkg::KindRx)
        else $error("reply sequence broken off");

    // the input side only stalls on a held item
    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> in_valid_reg && !no_result && !can_load)
        else $error("input stalled without a blocked item");

endmodule

@@ sv/scsd_core.sv @@
`timescale 1ns / 1ps
// command decode, digit store and scan ring
module scsd_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  scsd_pkg::item_t      item,
    input  logic                 take,
    output scsd_pkg::desc_t      desc
);

    localparam int N  = scsd_pkg::NumDigits;
    localparam int IW = scsd_pkg::IdxW;
    localparam logic [N-1:0] RingTop = {1'b1, {(N-1){1'b0}}};
    localparam logic [N-1:0] RingBottom = {{(N-1){1'b0}}, 1'b1};

    logic [3:0]    store_reg  [N];
    logic [3:0]    store_next [N];
    logic [3:0]    flags_reg, flags_next;
    logic [7:0]    count_reg, count_next;
    logic [IW-1:0] scan_reg, scan_next;
    logic [N-1:0]  ring_reg, ring_next;

    logic          scan_wrap;
    logic [IW-1:0] tick_idx;
    logic [N-1:0]  tick_ring;
    logic [7:0]    count_inc;

    always_comb
    begin
        scan_wrap = (ring_reg == RingTop)
                    || ((IW+1)'(scan_reg) + 1'b1 >= (IW+1)'(N));
        tick_idx  = scan_wrap ? '0 : scan_reg + 1'b1;
        tick_ring = scan_wrap ? RingBottom : (ring_reg << 1);
        count_inc = count_reg + 8'd1;

        store_next = store_reg;
        flags_next = flags_reg;
        count_next = count_reg;
        scan_next  = scan_reg;
        ring_next  = ring_reg;

        desc.kind         = scsd_pkg::RES_NONE;
        desc.segments     = '0;
        desc.digit_enable = '0;

        if (item.kind == scsd_pkg::KindScan)
        begin
            desc.kind         = scsd_pkg::RES_SCAN;
            desc.segments     = scsd_pkg::seg_code(store_reg[tick_idx]);
            desc.digit_enable = scsd_pkg::DriveW'(tick_ring);
            scan_next         = tick_idx;
            ring_next         = tick_ring;
        end
        else
        begin
            case (item.rx_byte)
                scsd_pkg::CharA:
                begin
                    flags_next = flags_reg | scsd_pkg::FlagA;
                end
                scsd_pkg::CharT:
                begin
                    flags_next = flags_reg | scsd_pkg::FlagT;
                end
                scsd_pkg::CharC:
                begin
                    flags_next = flags_reg | scsd_pkg::FlagC;
                    for (int i = 0; i < N; i++)
                        store_next[i] = scsd_pkg::BlankNibble;
                end
                scsd_pkg::CharN:
                begin
                    flags_next = flags_reg | scsd_pkg::FlagN;
                    for (int i = 0; i < N; i++)
                        store_next[i] = scsd_pkg::BlankNibble;
                end
                scsd_pkg::CharCr:
                begin
                    flags_next = flags_reg;
                end
                scsd_pkg::CharLf:
                begin
                    if (flags_reg == scsd_pkg::FlagsAt || flags_reg == scsd_pkg::FlagC
                        || flags_reg == scsd_pkg::FlagN)
                    begin
                        desc.kind  = scsd_pkg::RES_REPLY;
                        flags_next = '0;
                        if (flags_reg == scsd_pkg::FlagN)
                            count_next = '0;
                    end
                end
                default:
                begin
                    // digit: move older digits up unless this is the first one
                    count_next = count_inc;
                    if (count_inc != 8'd1)
                    begin
                        for (int i = 1; i < N; i++)
                            store_next[i] = store_reg[i-1];
                    end
                    store_next[0] = item.rx_byte[3:0];
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
                store_reg[i] <= scsd_pkg::BlankNibble;
            flags_reg <= '0;
            count_reg <= '0;
            scan_reg  <= '0;
            ring_reg  <= RingTop;
        end
        else if (take)
        begin
            store_reg <= store_next;
            flags_reg <= flags_next;
            count_reg <= count_next;
            scan_reg  <= scan_next;
            ring_reg  <= ring_next;
        end
    end

endmodule

@@ sv/scsd_out.sv @@
`timescale 1ns / 1ps
// result register and reply byte sequencer
module scsd_out (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  scsd_pkg::desc_t   desc,
    input  logic              result_ready,
    output logic              result_valid,
    output scsd_pkg::result_t result,
    output logic              can_load
);

    logic              valid_reg, valid_next;
    logic [1:0]        idx_reg, idx_next;
    scsd_pkg::result_t result_reg, result_next;
    logic [1:0]        idx_inc;

    always_comb
    begin
        can_load    = !valid_reg || (result_ready && result_reg.last);
        idx_inc     = idx_reg + 2'd1;
        valid_next  = valid_reg;
        idx_next    = idx_reg;
        result_next = result_reg;

        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = scsd_pkg::ReplyFirst;
            if (desc.kind == scsd_pkg::RES_SCAN)
            begin
                result_next.out_kind     = scsd_pkg::KindScan;
                result_next.tx_byte      = '0;
                result_next.segments     = desc.segments;
                result_next.digit_enable = desc.digit_enable;
                result_next.last         = 1'b1;
            end
            else
            begin
                result_next.out_kind     = scsd_pkg::KindRx;
                result_next.tx_byte      = scsd_pkg::reply_byte(scsd_pkg::ReplyFirst);
                result_next.segments     = '0;
                result_next.digit_enable = '0;
                result_next.last         = 1'b0;
            end
        end
        else if (valid_reg && result_ready)
        begin
            if (result_reg.last)
                valid_next = 1'b0;
            else
            begin
                idx_next            = idx_inc;
                result_next.tx_byte = scsd_pkg::reply_byte(idx_inc);
                result_next.last    = (idx_inc == scsd_pkg::ReplyLast);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule
